/* rtl/pgfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pgfd_pkg;

  localparam logic       MODE_STORE = 1'b0;
  localparam logic       MODE_READ  = 1'b1;

  localparam logic [1:0] LINK_DISC    = 2'd0;
  localparam logic [1:0] LINK_DIGITAL = 2'd1;
  localparam logic [1:0] LINK_ANALOG  = 2'd2;
  localparam logic [1:0] LINK_CONFIG  = 2'd3;

  localparam logic [7:0] ID_DIGITAL    = 8'h41;
  localparam logic [7:0] ID_ANALOG     = 8'h73;
  localparam logic [7:0] ID_ANALOG_EXT = 8'h79;
  localparam logic [7:0] ID_CONFIG     = 8'hF3;

  localparam logic [7:0] CMD_START = 8'h01;
  localparam logic [7:0] CMD_POLL  = 8'h42;
  localparam logic [7:0] CMD_IDLE  = 8'h00;

  localparam logic [4:0] LEN_RESET    = 5'd21;
  localparam logic [4:0] LEN_DISC     = 5'd2;
  localparam logic [4:0] LEN_DIGITAL  = 5'd5;
  localparam logic [4:0] LEN_ANALOG   = 5'd9;
  localparam logic [4:0] LEN_ANALOG_X = 5'd21;
  localparam logic [4:0] LEN_CONFIG   = 5'd9;

  localparam logic [15:0] BUTTONS_RESET = 16'h00FF;

  typedef struct packed {
    logic [1:0] link;
    logic [4:0] length;
  } id_info_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] released;
    logic [15:0] pressed;
    logic [15:0] buttons;
    logic [1:0]  link_mode;
    logic        frame_done;
    logic [7:0]  next_cmd;
  } result_t;

  function automatic id_info_t decode_id(input logic [7:0] id);
    id_info_t info;
    case (id)
      ID_DIGITAL: begin
        info.link   = LINK_DIGITAL;
        info.length = LEN_DIGITAL;
      end
      ID_ANALOG: begin
        info.link   = LINK_ANALOG;
        info.length = LEN_ANALOG;
      end
      ID_ANALOG_EXT: begin
        info.link   = LINK_ANALOG;
        info.length = LEN_ANALOG_X;
      end
      ID_CONFIG: begin
        info.link   = LINK_CONFIG;
        info.length = LEN_CONFIG;
      end
      default: begin
        info.link   = LINK_DISC;
        info.length = LEN_DISC;
      end
    endcase
    return info;
  endfunction

  function automatic logic [7:0] cmd_for(input logic [4:0] pos);
    logic [7:0] cmd;
    case (pos)
      5'd0:    cmd = CMD_START;
      5'd1:    cmd = CMD_POLL;
      default: cmd = CMD_IDLE;
    endcase
    return cmd;
  endfunction

endpackage

`default_nettype wire

/* rtl/pgfd_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module pgfd_core #(
  parameter int FRAME_BYTES = 21
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire                  mode,
  input  wire  [7:0]           rx_byte,
  input  wire  [4:0]           read_index,
  output pgfd_pkg::result_t    res
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [5:0] FRAME_END = 6'(FRAME_BYTES);

  logic [4:0]  byte_position;
  logic [4:0]  frame_length;
  logic [1:0]  device_mode;
  logic [15:0] buttons_now;
  logic [15:0] buttons_before;
  logic [7:0]  store [FRAME_BYTES];

  logic [4:0]  byte_position_next;
  logic [4:0]  frame_length_next;
  logic [1:0]  device_mode_next;
  logic [15:0] buttons_now_next;
  logic [15:0] buttons_before_next;

  pgfd_pkg::id_info_t id_info;
  logic [IDX_W-1:0]   pos_idx;
  logic [4:0]         len_eff;
  logic [5:0]         pos_inc;
  logic               store_beat;
  logic               frame_end;
  logic [7:0]         byte3;
  logic [7:0]         byte4;
  logic [7:0]         read_data;
  logic [15:0]        changed;

  assign pos_idx    = byte_position[IDX_W-1:0];
  assign id_info    = pgfd_pkg::decode_id(rx_byte);
  assign store_beat = (mode == pgfd_pkg::MODE_STORE);
  assign len_eff    = (byte_position == 5'd1) ? id_info.length : frame_length;
  assign pos_inc    = {1'b0, byte_position} + 6'd1;
  assign frame_end  = (pos_inc >= {1'b0, len_eff}) || (pos_inc >= FRAME_END);

  // bytes written this beat bypass the store
  always_comb begin
    if (byte_position == 5'd3) begin
      byte3 = rx_byte;
    end else if (byte_position == 5'd0) begin
      byte3 = '0;
    end else begin
      byte3 = store[3];
    end
    if (byte_position == 5'd4) begin
      byte4 = rx_byte;
    end else if (byte_position == 5'd0) begin
      byte4 = '0;
    end else begin
      byte4 = store[4];
    end
  end

  always_comb begin
    byte_position_next  = byte_position;
    frame_length_next   = frame_length;
    device_mode_next    = device_mode;
    buttons_now_next    = buttons_now;
    buttons_before_next = buttons_before;
    read_data           = '0;
    if (store_beat) begin
      if (byte_position == 5'd1) begin
        device_mode_next  = id_info.link;
        frame_length_next = id_info.length;
      end
      if (frame_end) begin
        buttons_before_next = buttons_now;
        buttons_now_next    = {byte4, byte3};
        byte_position_next  = '0;
      end else begin
        byte_position_next  = pos_inc[4:0];
      end
    end else if (device_mode == pgfd_pkg::LINK_ANALOG &&
                 {1'b0, read_index} < FRAME_END) begin
      read_data = store[read_index[IDX_W-1:0]];
    end
  end

  assign changed = buttons_now_next ^ buttons_before_next;

  always_comb begin
    res.next_cmd   = pgfd_pkg::cmd_for(byte_position_next);
    res.frame_done = store_beat && frame_end;
    res.link_mode  = device_mode_next;
    res.buttons    = buttons_now_next;
    res.pressed    = changed & ~buttons_now_next;
    res.released   = changed & ~buttons_before_next;
    res.read_data  = read_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      frame_length   <= pgfd_pkg::LEN_RESET;
      device_mode    <= pgfd_pkg::LINK_DISC;
      buttons_now    <= pgfd_pkg::BUTTONS_RESET;
      buttons_before <= pgfd_pkg::BUTTONS_RESET;
    end else if (push) begin
      byte_position  <= byte_position_next;
      frame_length   <= frame_length_next;
      device_mode    <= device_mode_next;
      buttons_now    <= buttons_now_next;
      buttons_before <= buttons_before_next;
    end
  end

  // response store, cleared by the first byte of a frame
  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (rst) begin
        store[i] <= '0;
      end else if (push && store_beat) begin
        if (pos_idx == IDX_W'(i)) begin
          store[i] <= rx_byte;
        end else if (byte_position == 5'd0) begin
          store[i] <= '0;
        end
      end
    end
  end

  position_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, byte_position} < FRAME_END)
    else $error("byte position beyond frame store");

  read_keeps_state: assert property (@(posedge clk) disable iff (rst)
    push && mode == pgfd_pkg::MODE_READ |=>
      $stable(byte_position) && $stable(device_mode) && $stable(buttons_now))
    else $error("read beat changed decoder state");

  done_restarts_frame: assert property (@(posedge clk) disable iff (rst)
    push && res.frame_done |=> byte_position == 5'd0)
    else $error("frame end did not restart position");

endmodule

`default_nettype wire

/* rtl/pgfd_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module pgfd_out_buf (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  pgfd_pkg::result_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output pgfd_pkg::result_t    out_data
);

  logic              main_valid;
  logic              skid_valid;
  pgfd_pkg::result_t main_data;
  pgfd_pkg::result_t skid_data;
  logic              push;
  logic              pop;

  assign in_ready  = !skid_valid;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid && out_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data  <= in_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= in_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end
  end

  skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid beat held without a head beat");

  head_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    main_valid && !out_ready |=> main_valid && $stable(main_data))
    else $error("stalled head beat changed");

endmodule

`default_nettype wire

/* rtl/gamepad_poll_frame_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Game-pad poll frame decoder. Each input beat either stores one response
// byte of a poll frame (tuser low) or reads back a stored byte (tuser high),
// and yields exactly one output beat: the next command byte, link mode,
// button word and pressed/released masks, the read byte, and tlast set on
// the beat that completed the frame. One beat is taken every cycle while the
// output buffer has room; the result is decoded combinationally and registered
// in a two-entry output buffer that absorbs a stalled sink.
module gamepad_poll_frame_decoder_top #(
  parameter int FRAME_BYTES = 21
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,  // rx_byte[7:0], read_index[12:8], zero pad
  input  wire         s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,  // next_cmd, link_mode, buttons, pressed,
                                     // released, read_data, zero pad
  output logic        m_axis_tlast   // frame_done
);

  pgfd_pkg::result_t res;
  pgfd_pkg::result_t out_res;
  logic              push;

  assign push = s_axis_tvalid && s_axis_tready;

  pgfd_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .mode       (s_axis_tuser),
    .rx_byte    (s_axis_tdata[7:0]),
    .read_index (s_axis_tdata[12:8]),
    .res        (res)
  );

  pgfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {6'b0, out_res.read_data, out_res.released, out_res.pressed,
                         out_res.buttons, out_res.link_mode, out_res.next_cmd};
  assign m_axis_tlast = out_res.frame_done;

endmodule

`default_nettype wire
